@@ rtl/core/swtm_pkg.sv @@
// Shared constants for the sliding window trimmed mean filter.
`default_nettype none
package swtm_pkg;
	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CFG_W           = 7;
	localparam logic [CFG_W-1:0] WLEN_RESET = 7'd5;
endpackage
`default_nettype wire

@@ rtl/core/swtm_ram.sv @@
// Generic simple dual port RAM with registered read data.
`default_nettype none
module swtm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/swtm_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncates toward zero.
`default_nettype none
module swtm_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 7
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [NUM_W-1:0] dividend,
	input  wire logic        [DEN_W-1:0] divisor,
	output logic                         done,
	output logic signed      [NUM_W-1:0] quotient
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] mag_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DEN_W:0]   trial;
	logic             fit;

	assign trial = {rem_q, mag_q[NUM_W-1]};
	assign fit   = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[NUM_W-1];
			mag_q <= dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			mag_q <= {mag_q[NUM_W-2:0], fit};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);
endmodule
`default_nettype wire

@@ rtl/core/sliding_window_trimmed_mean_top.sv @@
// Sliding window trimmed mean: one filtered value per sample.
// Each entry dropped from the back of either candidate queue and any output stall lengthen the work per sample;
// NUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) + 2 sets the bit-serial divider time.
// The block takes one sample at a time; the next sample is accepted once the result registers.
// Reset (or a window_length write) empties the window; RAM contents are not cleared.
`default_nettype none
module sliding_window_trimmed_mean_top #(
	parameter int MAX_WINDOW  = swtm_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swtm_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	output logic                               filtered_valid,
	input  wire logic                          filtered_stall,
	output logic signed      [SAMPLE_BITS-1:0] filtered,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [swtm_pkg::CFG_W-1:0]    window_length
);
	localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int TAG_W = $clog2(2 * MAX_WINDOW);
	localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
	localparam int NUM_W = SUM_W + 1;
	localparam int QE_W  = TAG_W + SAMPLE_BITS;
	localparam int CW    = swtm_pkg::CFG_W;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_RD_OLD  = 4'd1;
	localparam logic [3:0] ST_POP_MIN = 4'd2;
	localparam logic [3:0] ST_POP_MAX = 4'd3;
	localparam logic [3:0] ST_WR_RING = 4'd4;
	localparam logic [3:0] ST_Q_RD    = 4'd5;
	localparam logic [3:0] ST_Q_CMP   = 4'd6;
	localparam logic [3:0] ST_Q_WR    = 4'd7;
	localparam logic [3:0] ST_FRONT   = 4'd8;
	localparam logic [3:0] ST_FMIN    = 4'd9;
	localparam logic [3:0] ST_FMAX    = 4'd10;
	localparam logic [3:0] ST_DIV_GO  = 4'd11;
	localparam logic [3:0] ST_DIV     = 4'd12;
	localparam logic [3:0] ST_DONE    = 4'd13;

	logic [3:0]                    state_q;
	logic [CW-1:0]                 wlen_q;
	logic signed [SAMPLE_BITS-1:0] v_q;
	logic [TAG_W-1:0]              tick_q;
	logic [TAG_W-1:0]              oldtag_q;
	logic [PTR_W-1:0]              ring_head_q;
	logic [LEN_W-1:0]              held_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [PTR_W-1:0]              head_q [2];
	logic [LEN_W-1:0]              len_q  [2];
	logic                          sel_q;
	logic signed [SAMPLE_BITS-1:0] mn_q;
	logic signed [NUM_W-1:0]       num_q;
	logic [LEN_W-1:0]              den_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;
	logic                          filtered_valid_q;

	logic [LEN_W-1:0]       w_eff;
	logic [TAG_W:0]         period;
	logic [TAG_W:0]         tick_inc;
	logic [TAG_W-1:0]       tick_next;
	logic [TAG_W+1:0]       tag_sum;
	logic [LEN_W:0]         oldest_ext;
	logic [PTR_W-1:0]       oldest;

	logic                   ring_we;
	logic [PTR_W-1:0]       ring_raddr;
	logic [SAMPLE_BITS-1:0] ring_rdata;
	logic                   q_we;
	logic [PTR_W:0]         q_waddr;
	logic [PTR_W:0]         q_raddr;
	logic [QE_W-1:0]        q_wdata;
	logic [QE_W-1:0]        q_rdata;
	logic [TAG_W-1:0]       qr_tag;
	logic signed [SAMPLE_BITS-1:0] qr_val;
	logic                   drop;
	logic                   out_free;
	logic                   div_done;
	logic signed [NUM_W-1:0] div_quot;

	function automatic logic [PTR_W-1:0] qpos(input logic [PTR_W-1:0] h,
						  input logic [LEN_W-1:0] k);
		logic [LEN_W+1:0] s;
		s = (LEN_W+2)'(h) + (LEN_W+2)'(k);
		if (s >= (LEN_W+2)'(MAX_WINDOW)) begin
			s = s - (LEN_W+2)'(MAX_WINDOW);
		end
		return s[PTR_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] pinc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(MAX_WINDOW - 1)) ? '0 : p + 1'b1;
	endfunction

	// effective window, out-of-range values clamp
	always_comb begin
		if (wlen_q == '0) begin
			w_eff = LEN_W'(1);
		end else if ({1'b0, wlen_q} > (CW+1)'(MAX_WINDOW)) begin
			w_eff = LEN_W'(MAX_WINDOW);
		end else begin
			w_eff = LEN_W'(wlen_q);
		end
	end

	assign period    = (TAG_W+1)'(w_eff) << 1;
	assign tick_inc  = (TAG_W+1)'(tick_q) + 1'b1;
	assign tick_next = (tick_inc >= period) ? '0 : tick_inc[TAG_W-1:0];
	assign tag_sum   = (TAG_W+2)'(tick_q) + (TAG_W+2)'(w_eff);

	always_comb begin
		if ((LEN_W+1)'(ring_head_q) >= (LEN_W+1)'(held_q)) begin
			oldest_ext = (LEN_W+1)'(ring_head_q) - (LEN_W+1)'(held_q);
		end else begin
			oldest_ext = (LEN_W+1)'(ring_head_q) + (LEN_W+1)'(MAX_WINDOW)
				- (LEN_W+1)'(held_q);
		end
	end
	assign oldest = oldest_ext[PTR_W-1:0];

	assign qr_tag = q_rdata[QE_W-1:SAMPLE_BITS];
	assign qr_val = $signed(q_rdata[SAMPLE_BITS-1:0]);
	assign drop   = sel_q ? (qr_val < v_q) : (qr_val > v_q);

	assign cfg_ready      = (state_q == ST_IDLE);
	assign sample_stall   = (state_q != ST_IDLE) || cfg_valid;
	assign out_free       = !filtered_valid_q || !filtered_stall;
	assign filtered_valid = filtered_valid_q;
	assign filtered       = filtered_q;

	// memory port control; sel 0 is the min queue, 1 the max queue
	always_comb begin
		ring_we    = 1'b0;
		ring_raddr = oldest;
		q_we       = 1'b0;
		q_waddr    = {sel_q, qpos(head_q[sel_q], len_q[sel_q])};
		q_wdata    = {tick_q, v_q};
		q_raddr    = {1'b0, head_q[0]};
		unique case (state_q)
			ST_POP_MIN: q_raddr = {1'b1, head_q[1]};
			ST_WR_RING: ring_we = 1'b1;
			ST_Q_RD:    q_raddr = {sel_q, qpos(head_q[sel_q], len_q[sel_q] - 1'b1)};
			ST_Q_WR:    q_we = (len_q[sel_q] < LEN_W'(MAX_WINDOW));
			ST_FMIN:    q_raddr = {1'b1, head_q[1]};
			default:    q_raddr = {1'b0, head_q[0]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			wlen_q           <= swtm_pkg::WLEN_RESET;
			tick_q           <= '0;
			ring_head_q      <= '0;
			held_q           <= '0;
			sum_q            <= '0;
			head_q[0]        <= '0;
			head_q[1]        <= '0;
			len_q[0]         <= '0;
			len_q[1]         <= '0;
			sel_q            <= 1'b0;
			filtered_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				filtered_valid_q <= 1'b1;
			end else if (filtered_valid_q && !filtered_stall) begin
				filtered_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						wlen_q      <= window_length;
						tick_q      <= '0;
						ring_head_q <= '0;
						held_q      <= '0;
						sum_q       <= '0;
						head_q[0]   <= '0;
						head_q[1]   <= '0;
						len_q[0]    <= '0;
						len_q[1]    <= '0;
					end else if (sample_valid) begin
						tick_q  <= tick_next;
						state_q <= ST_RD_OLD;
					end
				end
				ST_RD_OLD: begin
					state_q <= (held_q >= w_eff) ? ST_POP_MIN : ST_WR_RING;
				end
				ST_POP_MIN: begin
					sum_q  <= sum_q - SUM_W'($signed(ring_rdata));
					held_q <= held_q - 1'b1;
					if (len_q[0] != '0 && qr_tag == oldtag_q) begin
						head_q[0] <= pinc(head_q[0]);
						len_q[0]  <= len_q[0] - 1'b1;
					end
					state_q <= ST_POP_MAX;
				end
				ST_POP_MAX: begin
					if (len_q[1] != '0 && qr_tag == oldtag_q) begin
						head_q[1] <= pinc(head_q[1]);
						len_q[1]  <= len_q[1] - 1'b1;
					end
					state_q <= ST_WR_RING;
				end
				ST_WR_RING: begin
					ring_head_q <= pinc(ring_head_q);
					held_q      <= held_q + 1'b1;
					sum_q       <= sum_q + SUM_W'(v_q);
					sel_q       <= 1'b0;
					state_q     <= ST_Q_RD;
				end
				ST_Q_RD: begin
					state_q <= (len_q[sel_q] != '0) ? ST_Q_CMP : ST_Q_WR;
				end
				ST_Q_CMP: begin
					if (drop) begin
						len_q[sel_q] <= len_q[sel_q] - 1'b1;
						state_q      <= ST_Q_RD;
					end else begin
						state_q <= ST_Q_WR;
					end
				end
				ST_Q_WR: begin
					if (q_we) begin
						len_q[sel_q] <= len_q[sel_q] + 1'b1;
					end
					if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= ST_Q_RD;
					end else begin
						state_q <= ST_FRONT;
					end
				end
				ST_FRONT: begin
					if (held_q > LEN_W'(2)) begin
						state_q <= ST_FMIN;
					end else begin
						num_q   <= NUM_W'(sum_q);
						den_q   <= held_q;
						state_q <= ST_DIV_GO;
					end
				end
				ST_FMIN: begin
					mn_q    <= qr_val;
					state_q <= ST_FMAX;
				end
				ST_FMAX: begin
					num_q   <= NUM_W'(sum_q) - NUM_W'(mn_q) - NUM_W'(qr_val);
					den_q   <= held_q - LEN_W'(2);
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && sample_valid && !cfg_valid) begin
			v_q <= sample;
		end
		if (state_q == ST_RD_OLD) begin
			oldtag_q <= (tag_sum >= (TAG_W+2)'(period))
				? TAG_W'(tag_sum - (TAG_W+2)'(period)) : tag_sum[TAG_W-1:0];
		end
		if (state_q == ST_DONE && out_free) begin
			filtered_q <= div_quot[SAMPLE_BITS-1:0];
		end
	end

	swtm_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WINDOW),
		.AW   (PTR_W)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_head_q),
		.wdata(v_q),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	swtm_ram #(
		.WIDTH(QE_W),
		.DEPTH(2 ** (PTR_W + 1)),
		.AW   (PTR_W + 1)
	) u_queue (
		.clk  (clk),
		.we   (q_we),
		.waddr(q_waddr),
		.wdata(q_wdata),
		.raddr(q_raddr),
		.rdata(q_rdata)
	);

	swtm_div #(
		.NUM_W(NUM_W),
		.DEN_W(LEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_DIV_GO),
		.dividend(num_q),
		.divisor (den_q),
		.done    (div_done),
		.quotient(div_quot)
	);
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the sliding window trimmed mean filter.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXW = swtm_pkg::MAX_WINDOW_DEF;
	localparam int SB = swtm_pkg::SAMPLE_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int FIFO_D = 8;

	class trim_mean_board;
		int unsigned wlen;
		logic signed [SB-1:0] ring [MAXW];
		int unsigned ring_head, held, tick;
		longint sum;
		int unsigned mn_tag [MAXW], mx_tag [MAXW];
		longint mn_val [MAXW], mx_val [MAXW];
		int unsigned mn_head, mn_len, mx_head, mx_len;
		logic signed [SB-1:0] want_fifo [FIFO_D];
		int unsigned wr_ptr, rd_ptr;
		int errors;

		function int unsigned backlog();
			return wr_ptr - rd_ptr;
		endfunction

		function void clear_window(int unsigned w);
			wlen = w;
			ring_head = 0;
			held = 0;
			tick = 0;
			sum = 0;
			mn_head = 0;
			mn_len = 0;
			mx_head = 0;
			mx_len = 0;
		endfunction

		function void note_sample(logic signed [SB-1:0] s);
			int unsigned w, period, old_tag, oldest, p;
			longint v, r;
			v = s;
			w = (wlen == 0) ? 1 : (wlen > MAXW ? MAXW : wlen);
			period = 2 * w;
			tick = (tick + 1) % period;
			if (held >= w) begin
				old_tag = (tick + w) % period;
				oldest = (ring_head + MAXW - (held % MAXW)) % MAXW;
				sum -= ring[oldest];
				held--;
				if (mn_len > 0 && mn_tag[mn_head] == old_tag) begin
					mn_head = (mn_head + 1) % MAXW;
					mn_len--;
				end
				if (mx_len > 0 && mx_tag[mx_head] == old_tag) begin
					mx_head = (mx_head + 1) % MAXW;
					mx_len--;
				end
			end
			ring[ring_head] = s;
			ring_head = (ring_head + 1) % MAXW;
			held++;
			sum += v;
			while (mn_len > 0 && mn_val[(mn_head + mn_len - 1) % MAXW] > v)
				mn_len--;
			if (mn_len < MAXW) begin
				p = (mn_head + mn_len) % MAXW;
				mn_tag[p] = tick;
				mn_val[p] = v;
				mn_len++;
			end
			while (mx_len > 0 && mx_val[(mx_head + mx_len - 1) % MAXW] < v)
				mx_len--;
			if (mx_len < MAXW) begin
				p = (mx_head + mx_len) % MAXW;
				mx_tag[p] = tick;
				mx_val[p] = v;
				mx_len++;
			end
			// SV division truncates toward zero
			if (held > 2)
				r = (sum - mn_val[mn_head] - mx_val[mx_head]) / longint'(held - 2);
			else
				r = sum / longint'(held);
			want_fifo[wr_ptr % FIFO_D] = SB'(r);
			wr_ptr++;
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_filtered(logic signed [SB-1:0] got);
			logic signed [SB-1:0] want;
			if (backlog() == 0) begin
				report_mismatch($sformatf("unexpected filtered %0d", got));
				return;
			end
			want = want_fifo[rd_ptr % FIFO_D];
			rd_ptr++;
			if (got !== want)
				report_mismatch($sformatf("filtered %0d, expected %0d", got, want));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic signed [SB-1:0] sample = '0;
	logic filtered_valid;
	logic filtered_stall = 1'b0;
	logic signed [SB-1:0] filtered;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [swtm_pkg::CFG_W-1:0] window_length = swtm_pkg::WLEN_RESET;

	trim_mean_board board = new();
	int send_idle_pct = 0, recv_idle_pct = 0;
	int quiet_cycles = 0;

	sliding_window_trimmed_mean_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.filtered_valid(filtered_valid), .filtered_stall(filtered_stall),
		.filtered(filtered),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .window_length(window_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: check beats, random stall, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (filtered_valid && !filtered_stall)
				board.check_filtered(filtered);
			if ((filtered_valid && !filtered_stall) || (sample_valid && !sample_stall)
					|| (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
		filtered_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// valid drops at the accepting edge, so beats never follow back to back
	task automatic send_sample(logic signed [SB-1:0] s);
		@(posedge clk);
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		board.note_sample(s);
		sample_valid <= 1'b0;
	endtask

	task automatic drain;
		while (board.backlog() != 0)
			@(posedge clk);
		repeat (2 * MAXW + 40) @(posedge clk);
	endtask

	task automatic write_window(logic [swtm_pkg::CFG_W-1:0] w);
		drain();
		cfg_valid <= 1'b1;
		window_length <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		board.clear_window(w);
	endtask

	function automatic logic signed [SB-1:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return SB'(int'($urandom_range(8)) - 4);
			default: return SB'($urandom);
		endcase
	endfunction

	task automatic run_phase(logic [swtm_pkg::CFG_W-1:0] w, int n);
		write_window(w);
		repeat (n) send_sample(rand_sample());
	endtask

	initial begin
		logic [swtm_pkg::CFG_W-1:0] wl [$];
		board.clear_window(swtm_pkg::WLEN_RESET);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 38;
		recv_idle_pct = 64;
		// directed: reset window, extremes and the small-count plain mean
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_sample(16'sh7fff);
		send_sample(-16'sd3);
		send_sample(16'sd0);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(16'sd5);
		send_sample(16'sh5555);
		send_sample(16'shaaaa);
		// out-of-range windows: zero acts as one, above max clamps
		write_window(7'd0);
		send_sample(16'sd7);
		send_sample(-16'sd9);
		write_window(7'd127);
		repeat (4) send_sample(16'sh8000);
		send_sample(16'sd100);
		send_sample(16'sd100);
		wl = '{7'd1, 7'd2, 7'd3, 7'd64, 7'd5, 7'd17, 7'd100, 7'd0, 7'd8, 7'd64};
		for (int i = 0; i < 4; i++) run_phase(wl[i], 160);
		send_idle_pct = 64;
		recv_idle_pct = 38;
		for (int i = 4; i < 7; i++) run_phase(wl[i], 200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 7; i < 10; i++) run_phase(wl[i], 150);
		run_phase(7'($urandom_range(1, 64)), 240);
		drain();
		if (board.errors == 0 && board.backlog() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
